@@ hw/rtl/tat_pkg.sv @@
// ----------------------------------------------------------------------------
// Token admission tracker package
// Shared codes and types for the token admission tracker.
// ----------------------------------------------------------------------------
package tat_pkg;

  // Request kinds carried on action_i.
  localparam logic ACT_ADMIT  = 1'b0;
  localparam logic ACT_RETURN = 1'b1;

  typedef enum logic [2:0] {
    STATUS_ADMITTED   = 3'd0,
    STATUS_DROPPED    = 3'd1,
    STATUS_CONTROLLED = 3'd2,
    STATUS_RETURNED   = 3'd3,
    STATUS_NOT_ISSUED = 3'd4
  } status_e;

  // Outcome of one pass over the holder table.
  typedef struct packed {
    logic done;    // one-cycle pulse, the other fields are valid with it
    logic hit;     // a valid entry holds the key
    logic vacant;  // at least one entry is not valid
  } scan_flags_t;

endpackage

@@ hw/rtl/tat_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tat_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tat_lookup.sv @@
// ----------------------------------------------------------------------------
// Token admission tracker lookup
// Holds the id table in RAM and walks it one entry per cycle, looking for
// the key among valid entries and for the first entry that is not valid.
// ----------------------------------------------------------------------------
module tat_lookup #(
  parameter int NUM_SLOTS = 16,
  parameter int ID_BITS   = 32
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             scan_i,
  input  logic [ID_BITS-1:0]                               key_i,
  input  logic [NUM_SLOTS-1:0]                             valid_i,
  input  logic                                             wr_en_i,
  input  logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] wr_idx_i,
  output tat_pkg::scan_flags_t                             flags_o,
  output logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] hit_idx_o,
  output logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] vac_idx_o
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CntW = $clog2(NUM_SLOTS + 1);

  localparam logic [CntW-1:0] LastCnt = CntW'(NUM_SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  logic            done_q, done_d;
  logic            hit_q, hit_d;
  logic            vac_q, vac_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [IdxW-1:0] vac_idx_q, vac_idx_d;

  logic               rd_en;
  logic [IdxW-1:0]    rd_addr;
  logic [ID_BITS-1:0] rd_data;

  assign rd_en   = busy_q && (rd_cnt_q != LastCnt);
  assign rd_addr = rd_cnt_q[IdxW-1:0];

  tat_ram #(
    .Width(ID_BITS),
    .Depth(NUM_SLOTS)
  ) u_id_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_idx_i),
    .wdata_i(key_i),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_comb begin
    busy_d     = busy_q;
    rd_cnt_d   = rd_cnt_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    done_d     = 1'b0;
    hit_d      = hit_q;
    vac_d      = vac_q;
    hit_idx_d  = hit_idx_q;
    vac_idx_d  = vac_idx_q;

    if (scan_i) begin
      busy_d   = 1'b1;
      rd_cnt_d = '0;
      hit_d    = 1'b0;
      vac_d    = 1'b0;
    end else if (busy_q) begin
      if (rd_en) begin
        pend_d     = 1'b1;
        pend_idx_d = rd_addr;
        rd_cnt_d   = rd_cnt_q + CntW'(1);
      end
      // Read data arrives in the cycle after the address; the entry that it
      // belongs to travels alongside in pend_idx_q.
      if (pend_q) begin
        if (valid_i[pend_idx_q]) begin
          if (!hit_q && rd_data == key_i) begin
            hit_d     = 1'b1;
            hit_idx_d = pend_idx_q;
          end
        end else if (!vac_q) begin
          vac_d     = 1'b1;
          vac_idx_d = pend_idx_q;
        end
        if (pend_idx_q == LastIdx) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rd_cnt_q <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
      vac_q    <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      rd_cnt_q <= rd_cnt_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
      hit_q    <= hit_d;
      vac_q    <= vac_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
    vac_idx_q  <= vac_idx_d;
  end

  assign flags_o.done   = done_q;
  assign flags_o.hit    = hit_q;
  assign flags_o.vacant = vac_q;
  assign hit_idx_o      = hit_idx_q;
  assign vac_idx_o      = vac_idx_q;

endmodule

@@ hw/rtl/token_admission_tracker.sv @@
// ----------------------------------------------------------------------------
// Token admission tracker
// Credit-based admission gate with a table of the frame ids holding tokens.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. action_i selects
// admit or return, frame_id_i names the frame, already_controlled_i matters
// for admits only. Each request produces exactly one result: status_o and
// tokens_free_o are valid while done_o is high for a single cycle. There is
// no backpressure on results; the receiver must take them when they appear.
// An admit flagged as controlled, or an admit with no free token, is
// answered in the cycle after the request and the block is ready again at
// once. Every other request walks the id table in RAM, one entry per cycle
// through its single read port while busy stays high, and the next request
// can be taken in the cycle in which its result appears. The table entry is
// written back at the edge where busy drops, so consecutive requests never
// overlap on an entry. The limit register is written over the cfg channel,
// which is ready only while no scan is running; a write reloads the free
// count with the limit (capped at NUM_SLOTS, or 31 if that is smaller) and
// releases every held token. Reset does the same with a limit of 16, or
// NUM_SLOTS if that is smaller.
// ----------------------------------------------------------------------------
module token_admission_tracker #(
  parameter int NUM_SLOTS = 16,
  parameter int ID_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [31:0] frame_id_i,
  input  logic        already_controlled_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [4:0]  tokens_free_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  localparam int IdxW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LimCap   = (NUM_SLOTS > 31) ? 31 : NUM_SLOTS;
  localparam int RstLimit = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state_q, state_d;
  logic                 action_q, action_d;
  logic [ID_BITS-1:0]   key_q, key_d;
  logic [4:0]           free_q, free_d;
  logic [4:0]           limit_q, limit_d;
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic                 done_q, done_d;
  tat_pkg::status_e     status_q, status_d;

  logic                 accept;
  logic                 cfg_write;
  logic                 scan;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_idx;
  logic [63:0]          id_ext;
  logic [4:0]           cfg_limit;
  tat_pkg::scan_flags_t flags;
  logic [IdxW-1:0]      hit_idx;
  logic [IdxW-1:0]      vac_idx;

  assign busy        = (state_q == ST_SCAN);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign id_ext      = {32'd0, frame_id_i};
  assign cfg_limit   = (cfg_data_i > 5'(LimCap)) ? 5'(LimCap) : cfg_data_i;

  always_comb begin
    state_d  = state_q;
    action_d = action_q;
    key_d    = key_q;
    free_d   = free_q;
    limit_d  = limit_q;
    valid_d  = valid_q;
    done_d   = 1'b0;
    status_d = status_q;
    scan     = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = vac_idx;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_write) begin
          limit_d = cfg_limit;
          free_d  = cfg_limit;
          valid_d = '0;
        end
        // A limit write in the same cycle takes effect before the request.
        if (accept) begin
          action_d = action_i;
          key_d    = id_ext[ID_BITS-1:0];
          if (action_i == tat_pkg::ACT_ADMIT && already_controlled_i) begin
            done_d   = 1'b1;
            status_d = tat_pkg::STATUS_CONTROLLED;
          end else if (action_i == tat_pkg::ACT_ADMIT && free_d == 5'd0) begin
            done_d   = 1'b1;
            status_d = tat_pkg::STATUS_DROPPED;
          end else begin
            scan    = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (flags.done) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (action_q == tat_pkg::ACT_ADMIT) begin
            if (flags.hit) begin
              // The id already holds a token: take one more, keep one entry.
              free_d   = free_q - 5'd1;
              status_d = tat_pkg::STATUS_ADMITTED;
            end else if (flags.vacant) begin
              wr_en            = 1'b1;
              valid_d[vac_idx] = 1'b1;
              free_d           = free_q - 5'd1;
              status_d         = tat_pkg::STATUS_ADMITTED;
            end else begin
              status_d = tat_pkg::STATUS_DROPPED;
            end
          end else begin
            if (flags.hit) begin
              valid_d[hit_idx] = 1'b0;
              if (free_q < limit_q) begin
                free_d = free_q + 5'd1;
              end
              status_d = tat_pkg::STATUS_RETURNED;
            end else begin
              status_d = tat_pkg::STATUS_NOT_ISSUED;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  tat_lookup #(
    .NUM_SLOTS(NUM_SLOTS),
    .ID_BITS  (ID_BITS)
  ) u_lookup (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .scan_i   (scan),
    .key_i    (key_d),
    .valid_i  (valid_q),
    .wr_en_i  (wr_en),
    .wr_idx_i (wr_idx),
    .flags_o  (flags),
    .hit_idx_o(hit_idx),
    .vac_idx_o(vac_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      action_q <= tat_pkg::ACT_ADMIT;
      free_q   <= 5'(RstLimit);
      limit_q  <= 5'(RstLimit);
      valid_q  <= '0;
      done_q   <= 1'b0;
      status_q <= tat_pkg::STATUS_ADMITTED;
    end else begin
      state_q  <= state_d;
      action_q <= action_d;
      free_q   <= free_d;
      limit_q  <= limit_d;
      valid_q  <= valid_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign tokens_free_o = free_q;

endmodule
